>>> rtl/blpf_pkg.sv
package blpf_pkg;

    // Packet framing constants.
    localparam logic [7:0]  FRAME_HEADER = 8'h80;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
    localparam logic [7:0]  MAX_PAYLOAD  = 8'd255;

    // Input opcodes.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Output slots of one packet, in transmit order.
    localparam logic [2:0] SLOT_HDR    = 3'd0;
    localparam logic [2:0] SLOT_LEN_LO = 3'd1;
    localparam logic [2:0] SLOT_LEN_HI = 3'd2;
    localparam logic [2:0] SLOT_DATA   = 3'd3;
    localparam logic [2:0] SLOT_CRC0   = 3'd4;
    localparam logic [2:0] SLOT_CRC1   = 3'd5;
    localparam logic [2:0] SLOT_CRC2   = 3'd6;
    localparam logic [2:0] SLOT_CRC3   = 3'd7;

    // One job handed from the front end to the back end: a run of slots to emit.
    typedef struct packed {
        logic        err;
        logic [2:0]  first_slot;
        logic [2:0]  last_slot;
        logic [7:0]  data;
        logic [7:0]  len_lo;
        logic        len_hi;
        logic [31:0] crc;
    } job_t;

    // Reflected CRC-32 update over one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/blpf_front.sv
module blpf_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    input  logic [7:0]        s_command_code,
    input  logic [7:0]        s_payload_length,
    input  logic [7:0]        s_payload_byte,
    input  logic              q_full,
    output logic              q_push,
    output blpf_pkg::job_t    q_job
);

    logic        open_reg, open_next;
    logic [7:0]  remain_reg, remain_next;
    logic [31:0] crc_reg, crc_next;

    logic        accept;
    logic [31:0] crc_upd;
    logic [8:0]  total;
    logic [7:0]  remain_dec;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    // Classify the transaction, update packet state and build the job.
    always_comb begin
        open_next   = open_reg;
        remain_next = remain_reg;
        crc_next    = crc_reg;
        total       = {1'b0, s_payload_length} + 9'd1;
        remain_dec  = remain_reg - 8'd1;
        crc_upd     = blpf_pkg::crc_byte((s_opcode == blpf_pkg::OP_START) ?
                                         blpf_pkg::CRC_INIT : crc_reg,
                                         (s_opcode == blpf_pkg::OP_START) ?
                                         s_command_code : s_payload_byte);

        q_job            = '0;
        q_job.err        = 1'b1;
        q_job.first_slot = blpf_pkg::SLOT_DATA;
        q_job.last_slot  = blpf_pkg::SLOT_DATA;
        q_job.len_lo     = total[7:0];
        q_job.len_hi     = total[8];

        if (s_opcode == blpf_pkg::OP_START) begin
            if (!open_reg && s_payload_length <= blpf_pkg::MAX_PAYLOAD) begin
                q_job.err        = 1'b0;
                q_job.data       = s_command_code;
                q_job.first_slot = blpf_pkg::SLOT_HDR;
                if (s_payload_length == 8'd0) begin
                    q_job.last_slot = blpf_pkg::SLOT_CRC3;
                    q_job.crc       = ~crc_upd;
                end else begin
                    open_next   = 1'b1;
                    remain_next = s_payload_length;
                    crc_next    = crc_upd;
                end
            end
        end else begin
            if (open_reg && remain_reg != 8'd0) begin
                q_job.err  = 1'b0;
                q_job.data = s_payload_byte;
                if (remain_dec == 8'd0) begin
                    q_job.last_slot = blpf_pkg::SLOT_CRC3;
                    q_job.crc       = ~crc_upd;
                    open_next       = 1'b0;
                    remain_next     = 8'd0;
                    crc_next        = blpf_pkg::CRC_INIT;
                end else begin
                    remain_next = remain_dec;
                    crc_next    = crc_upd;
                end
            end
        end
    end

    // Packet state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg   <= 1'b0;
            remain_reg <= 8'd0;
            crc_reg    <= blpf_pkg::CRC_INIT;
        end else if (accept) begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
            crc_reg    <= crc_next;
        end
    end

endmodule

>>> rtl/blpf_fifo.sv
module blpf_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  blpf_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output blpf_pkg::job_t head_job,
    output logic           not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    blpf_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = entry_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    // Job storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/blpf_back.sv
module blpf_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  blpf_pkg::job_t head_job,
    input  logic           head_valid,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_tx_byte,
    output logic           m_last_of_run,
    output logic           m_packet_end,
    output logic           m_sequence_error
);

    logic       started_reg;
    logic [2:0] slot_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg, end_reg, err_reg;

    logic [2:0] cur_slot;
    logic       load;
    logic       is_last;
    logic [7:0] byte_next;

    assign cur_slot = started_reg ? slot_reg : head_job.first_slot;
    assign load     = head_valid && (!valid_reg || m_ready);
    assign is_last  = (cur_slot == head_job.last_slot);
    assign pop      = load && is_last;

    // Select the byte for the current slot.
    always_comb begin
        case (cur_slot)
            blpf_pkg::SLOT_HDR:    byte_next = blpf_pkg::FRAME_HEADER;
            blpf_pkg::SLOT_LEN_LO: byte_next = head_job.len_lo;
            blpf_pkg::SLOT_LEN_HI: byte_next = {7'd0, head_job.len_hi};
            blpf_pkg::SLOT_DATA:   byte_next = head_job.data;
            blpf_pkg::SLOT_CRC0:   byte_next = head_job.crc[7:0];
            blpf_pkg::SLOT_CRC1:   byte_next = head_job.crc[15:8];
            blpf_pkg::SLOT_CRC2:   byte_next = head_job.crc[23:16];
            blpf_pkg::SLOT_CRC3:   byte_next = head_job.crc[31:24];
            default:               byte_next = 8'd0;
        endcase
    end

    // Slot sequencing and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            slot_reg    <= blpf_pkg::SLOT_HDR;
            valid_reg   <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                if (is_last) begin
                    started_reg <= 1'b0;
                end else begin
                    started_reg <= 1'b1;
                    slot_reg    <= cur_slot + 3'd1;
                end
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_next;
            last_reg <= is_last;
            end_reg  <= (cur_slot == blpf_pkg::SLOT_CRC3);
            err_reg  <= head_job.err;
        end
    end

    assign m_valid          = valid_reg;
    assign m_tx_byte        = byte_reg;
    assign m_last_of_run    = last_reg;
    assign m_packet_end     = end_reg;
    assign m_sequence_error = err_reg;

endmodule

>>> rtl/boot_loader_packet_framer.sv
// Boot-loader packet framer. A start transaction (opcode 0) opens a packet and
// yields the header 0x80, the 16-bit length (command plus payload, LSB first)
// and the command byte; each payload transaction (opcode 1) yields its byte,
// and the packet's last payload byte is followed by the four CRC-32 bytes, LSB
// first. A zero-length start yields all eight bytes at once. Out-of-sequence
// transactions yield one result with sequence_error set and tx_byte 0. The
// input side takes one transaction per cycle while the job queue has room;
// the output side sends one byte per cycle while m_ready holds high; each
// transaction yields one byte (payload or error), four (start), five (closing
// payload) or eight (zero-length start). The output serializer sets the
// sustained rate; a queue of FIFO_DEPTH jobs absorbs header and CRC bursts.
module boot_loader_packet_framer #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_opcode,
    input  logic [7:0] s_command_code,
    input  logic [7:0] s_payload_length,
    input  logic [7:0] s_payload_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_last_of_run,
    output logic       m_packet_end,
    output logic       m_sequence_error
);

    blpf_pkg::job_t push_job;
    blpf_pkg::job_t head_job;
    logic           push;
    logic           full;
    logic           pop;
    logic           not_empty;

    // Front end: accepts and classifies transactions.
    blpf_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_command_code   (s_command_code),
        .s_payload_length (s_payload_length),
        .s_payload_byte   (s_payload_byte),
        .q_full           (full),
        .q_push           (push),
        .q_job            (push_job)
    );

    // Job queue between the two sides.
    blpf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (not_empty)
    );

    // Back end: serializes each job into output bytes.
    blpf_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_job         (head_job),
        .head_valid       (not_empty),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tx_byte        (m_tx_byte),
        .m_last_of_run    (m_last_of_run),
        .m_packet_end     (m_packet_end),
        .m_sequence_error (m_sequence_error)
    );

endmodule
